// File: design/twkb_pkg.sv
// Package for the TWKB stream decoder: phase codes, field widths, result kinds.
// No dependencies.
package twkb_pkg;

    localparam int CountWidth     = 32;
    localparam int VarintMaxBytes = 10;
    localparam int ShiftLimit     = VarintMaxBytes * 7;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_META    = 4'd1,
        PH_EXT     = 4'd2,
        PH_SIZE    = 4'd3,
        PH_BBOX    = 4'd4,
        PH_NPARTS  = 4'd5,
        PH_IDLIST  = 4'd6,
        PH_NRINGS  = 4'd7,
        PH_NPOINTS = 4'd8,
        PH_COORD   = 4'd9,
        PH_DONE    = 4'd10
    } phase_t;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_UNSUPP    = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [63:0] x_coord;
        logic signed [63:0] y_coord;
        logic signed [3:0] precision_xy;
        logic [3:0]        geom_type;
        logic              ring_end;
        logic              part_end;
        logic              geom_end;
        logic [1:0]        status;
    } result_t;

endpackage

// File: design/twkb_parser.sv
// Byte parser of the TWKB stream decoder: phase register, varint and accumulators.
// Depends on twkb_pkg.
module twkb_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic [7:0]              data_byte,
    input  logic                    first_byte,
    input  logic                    last_byte,
    output logic                    res_valid,
    output twkb_pkg::result_t       res
);

    localparam int CW = twkb_pkg::CountWidth;

    twkb_pkg::phase_t phase_reg, phase_next;
    logic [63:0]   vacc_reg, vacc_next;
    logic [6:0]    vsh_reg, vsh_next;
    logic [63:0]   ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next, am_reg, am_next;
    logic [7:0]    flags_reg, flags_next;
    logic [7:0]    tp_reg, tp_next;
    logic [CW-1:0] parts_reg, parts_next, rings_reg, rings_next;
    logic [CW-1:0] points_reg, points_next, skip_reg, skip_next;
    logic [1:0]    fip_reg, fip_next;

    // Scratch for the combinational step
    logic [63:0]   v, d, vacc_or;
    logic [CW-1:0] c, pdec, rdec, sdec;
    logic [3:0]    gt, p;
    logic          vdone, emit, ptdone, hz, hm;
    logic          fr, fp, fg;
    logic [1:0]    kind, status;
    logic [63:0]   ox, oy;

    always_comb begin
        phase_next  = phase_reg;
        vacc_next   = vacc_reg;
        vsh_next    = vsh_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        am_next     = am_reg;
        flags_next  = flags_reg;
        tp_next     = tp_reg;
        parts_next  = parts_reg;
        rings_next  = rings_reg;
        points_next = points_reg;
        skip_next   = skip_reg;
        fip_next    = fip_reg;
        emit = 1'b0; kind = twkb_pkg::KIND_POINT; status = twkb_pkg::ST_OK;
        fr = 1'b0; fp = 1'b0; fg = 1'b0; ox = '0; oy = '0; ptdone = 1'b0;
        gt = tp_reg[3:0];
        hz = flags_reg[5];
        hm = flags_reg[6];

        // Feed varint byte
        vacc_or = vacc_reg;
        if (vsh_reg < 7'd64 && 32'(vsh_reg) < twkb_pkg::ShiftLimit)
            vacc_or = vacc_reg | ({57'd0, data_byte[6:0]} << vsh_reg[5:0]);
        vdone = ~data_byte[7];
        v = vacc_or;
        c = v[CW-1:0];
        d = (v >> 1) ^ (64'd0 - {63'd0, v[0]});
        pdec = points_reg - 1'b1;
        rdec = rings_reg - 1'b1;
        sdec = skip_reg - 1'b1;

        if (first_byte || phase_reg == twkb_pkg::PH_HEAD) begin
            vacc_next = '0; vsh_next = '0;
            ax_next = '0; ay_next = '0; az_next = '0; am_next = '0;
            flags_next = '0; parts_next = '0; rings_next = '0;
            points_next = '0; skip_next = '0; fip_next = '0;
            tp_next = data_byte;
            phase_next = twkb_pkg::PH_META;
            gt = data_byte[3:0];
        end else if (phase_reg == twkb_pkg::PH_META || phase_reg == twkb_pkg::PH_EXT) begin
            if (phase_reg == twkb_pkg::PH_META)
                flags_next = {3'd0, data_byte[4:0]};
            else
                flags_next = flags_reg | {1'b0, data_byte[1], data_byte[0], 5'd0};
            if (phase_reg == twkb_pkg::PH_META && data_byte[3]) begin
                phase_next = twkb_pkg::PH_EXT;
            end else if (flags_next[4]) begin
                emit = 1'b1; kind = twkb_pkg::KIND_ERROR; fg = 1'b1;
                status = twkb_pkg::ST_EMPTY; phase_next = twkb_pkg::PH_DONE;
            end else if (gt == 4'd0 || gt > 4'd6) begin
                emit = 1'b1; kind = twkb_pkg::KIND_ERROR; fg = 1'b1;
                status = twkb_pkg::ST_UNSUPP; phase_next = twkb_pkg::PH_DONE;
            end else if (flags_next[1]) begin
                phase_next = twkb_pkg::PH_SIZE;
            end else if (flags_next[0]) begin
                skip_next = CW'(4 + 2 * int'(flags_next[5]) + 2 * int'(flags_next[6]));
                phase_next = twkb_pkg::PH_BBOX;
            end else begin
                case (gt)
                    4'd1: begin points_next = CW'(1); fip_next = '0;
                        phase_next = twkb_pkg::PH_COORD; end
                    4'd2: phase_next = twkb_pkg::PH_NPOINTS;
                    4'd3: phase_next = twkb_pkg::PH_NRINGS;
                    default: phase_next = twkb_pkg::PH_NPARTS;
                endcase
            end
        end else if (phase_reg != twkb_pkg::PH_DONE) begin
            vacc_next = vacc_or;
            if (32'(vsh_reg) < twkb_pkg::ShiftLimit) vsh_next = vsh_reg + 7'd7;
            if (vdone) begin
                vacc_next = '0; vsh_next = '0;
                case (phase_reg)
                    twkb_pkg::PH_SIZE: begin
                        if (flags_reg[0]) begin
                            skip_next = CW'(4 + 2 * int'(hz) + 2 * int'(hm));
                            phase_next = twkb_pkg::PH_BBOX;
                        end else begin
                            case (gt)
                                4'd1: begin points_next = CW'(1); fip_next = '0;
                                    phase_next = twkb_pkg::PH_COORD; end
                                4'd2: phase_next = twkb_pkg::PH_NPOINTS;
                                4'd3: phase_next = twkb_pkg::PH_NRINGS;
                                default: phase_next = twkb_pkg::PH_NPARTS;
                            endcase
                        end
                    end
                    twkb_pkg::PH_BBOX: begin
                        skip_next = sdec;
                        if (sdec == '0) begin
                            case (gt)
                                4'd1: begin points_next = CW'(1); fip_next = '0;
                                    phase_next = twkb_pkg::PH_COORD; end
                                4'd2: phase_next = twkb_pkg::PH_NPOINTS;
                                4'd3: phase_next = twkb_pkg::PH_NRINGS;
                                default: phase_next = twkb_pkg::PH_NPARTS;
                            endcase
                        end
                    end
                    twkb_pkg::PH_NPARTS: begin
                        parts_next = c;
                        if (c == '0) begin
                            emit = 1'b1; kind = twkb_pkg::KIND_END; fg = 1'b1;
                            phase_next = twkb_pkg::PH_DONE;
                        end else if (flags_reg[2]) begin
                            skip_next = c; phase_next = twkb_pkg::PH_IDLIST;
                        end else if (gt == 4'd4) begin
                            points_next = CW'(1); fip_next = '0;
                            phase_next = twkb_pkg::PH_COORD;
                        end else if (gt == 4'd5) phase_next = twkb_pkg::PH_NPOINTS;
                        else phase_next = twkb_pkg::PH_NRINGS;
                    end
                    twkb_pkg::PH_IDLIST: begin
                        skip_next = sdec;
                        if (sdec == '0) begin
                            if (gt == 4'd4) begin
                                points_next = CW'(1); fip_next = '0;
                                phase_next = twkb_pkg::PH_COORD;
                            end else if (gt == 4'd5) phase_next = twkb_pkg::PH_NPOINTS;
                            else phase_next = twkb_pkg::PH_NRINGS;
                        end
                    end
                    twkb_pkg::PH_NRINGS: begin
                        rings_next = c;
                        if (c == '0) begin
                            emit = 1'b1; kind = twkb_pkg::KIND_END;
                            if (gt == 4'd3) begin
                                fg = 1'b1; phase_next = twkb_pkg::PH_DONE;
                            end else begin
                                parts_next = parts_reg - 1'b1; fp = 1'b1;
                                if (parts_next == '0) begin
                                    fg = 1'b1; phase_next = twkb_pkg::PH_DONE;
                                end else phase_next = twkb_pkg::PH_NRINGS;
                            end
                        end else phase_next = twkb_pkg::PH_NPOINTS;
                    end
                    twkb_pkg::PH_NPOINTS: begin
                        if (c == '0) begin
                            emit = 1'b1; kind = twkb_pkg::KIND_END; ptdone = 1'b1;
                        end else begin
                            points_next = c; fip_next = '0;
                            phase_next = twkb_pkg::PH_COORD;
                        end
                    end
                    default: begin
                        case (fip_reg)
                            2'd0: begin ax_next = ax_reg + d; fip_next = 2'd1; end
                            2'd1: begin
                                ay_next = ay_reg + d;
                                if (hz) fip_next = 2'd2;
                                else if (hm) fip_next = 2'd3;
                                else ptdone = 1'b1;
                            end
                            2'd2: begin
                                az_next = az_reg + d;
                                if (hm) fip_next = 2'd3; else ptdone = 1'b1;
                            end
                            default: begin am_next = am_reg + d; ptdone = 1'b1; end
                        endcase
                        if (ptdone) begin
                            fip_next = '0; points_next = pdec;
                            emit = 1'b1; kind = twkb_pkg::KIND_POINT;
                            ox = ax_next; oy = ay_next;
                            if (pdec != '0) ptdone = 1'b0;
                        end
                    end
                endcase
                // Close the point list: walk the ring/part/geometry ends
                if (ptdone) begin
                    case (gt)
                        4'd1: begin fg = 1'b1; phase_next = twkb_pkg::PH_DONE; end
                        4'd2: begin fr = 1'b1; fg = 1'b1; phase_next = twkb_pkg::PH_DONE; end
                        4'd4, 4'd5: begin
                            fr = (gt == 4'd5); fp = 1'b1;
                            parts_next = parts_reg - 1'b1;
                            if (parts_next == '0) begin
                                fg = 1'b1; phase_next = twkb_pkg::PH_DONE;
                            end else if (gt == 4'd4) begin
                                points_next = CW'(1); fip_next = '0;
                                phase_next = twkb_pkg::PH_COORD;
                            end else phase_next = twkb_pkg::PH_NPOINTS;
                        end
                        default: begin
                            fr = 1'b1; rings_next = rdec;
                            if (rdec != '0) phase_next = twkb_pkg::PH_NPOINTS;
                            else if (gt == 4'd3) begin
                                fg = 1'b1; phase_next = twkb_pkg::PH_DONE;
                            end else begin
                                fp = 1'b1; parts_next = parts_reg - 1'b1;
                                if (parts_next == '0) begin
                                    fg = 1'b1; phase_next = twkb_pkg::PH_DONE;
                                end else phase_next = twkb_pkg::PH_NRINGS;
                            end
                        end
                    endcase
                end
            end
        end

        // Truncation overrides any record of this byte
        if (last_byte && phase_next != twkb_pkg::PH_DONE) begin
            emit = 1'b1; kind = twkb_pkg::KIND_ERROR; status = twkb_pkg::ST_TRUNCATED;
            fr = 1'b0; fp = 1'b0; fg = 1'b1; ox = '0; oy = '0;
            phase_next = twkb_pkg::PH_DONE; vacc_next = '0; vsh_next = '0;
        end

        p = tp_next[7:4];
        res.kind         = kind;
        res.x_coord      = ox;
        res.y_coord      = oy;
        res.precision_xy = p[0] ? (4'd0 - {1'b0, p[3:1]} - 4'd1) : {1'b0, p[3:1]};
        res.geom_type    = tp_next[3:0];
        res.ring_end     = fr;
        res.part_end     = fp;
        res.geom_end     = fg;
        res.status       = status;
        res_valid        = in_valid & emit;
    end

    // Advance the parser state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= twkb_pkg::PH_HEAD;
            vacc_reg <= '0; vsh_reg <= '0;
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0; am_reg <= '0;
            flags_reg <= '0; tp_reg <= '0;
            parts_reg <= '0; rings_reg <= '0; points_reg <= '0; skip_reg <= '0;
            fip_reg <= '0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            vacc_reg <= vacc_next; vsh_reg <= vsh_next;
            ax_reg <= ax_next; ay_reg <= ay_next; az_reg <= az_next; am_reg <= am_next;
            flags_reg <= flags_next; tp_reg <= tp_next;
            parts_reg <= parts_next; rings_reg <= rings_next;
            points_reg <= points_next; skip_reg <= skip_next;
            fip_reg <= fip_next;
        end
    end

endmodule

// File: design/twkb_out_reg.sv
// Result register with skid stage for the TWKB stream decoder.
// Depends on twkb_pkg.
module twkb_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  twkb_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    output twkb_pkg::result_t out_data,
    input  logic              out_ready
);

    logic              main_v_reg, skid_v_reg;
    twkb_pkg::result_t main_reg, skid_reg;

    assign in_ready  = ~skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    // Hold results; spill to the skid slot when the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (!main_v_reg || out_ready) begin
                if (skid_v_reg) begin
                    main_v_reg <= 1'b1;
                    main_reg   <= skid_reg;
                    skid_v_reg <= 1'b0;
                end else begin
                    main_v_reg <= in_valid;
                    if (in_valid) main_reg <= in_data;
                end
            end else if (in_valid && !skid_v_reg) begin
                skid_v_reg <= 1'b1;
                skid_reg   <= in_data;
            end
        end
    end

endmodule

// File: design/twkb_geometry_stream_decoder_unit.sv
// Top level of the TWKB stream decoder: byte parser and result register.
// Depends on twkb_pkg, twkb_parser, twkb_out_reg.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_data_byte s_first_byte s_last_byte
//  m_      | out       | m_valid m_ready m_kind m_x_coord ... m_status
//
// One byte per cycle while s_ready is high; each byte finishes in the parser logic in the cycle it is
// taken, and its record, if any, is registered in the result register before it appears at m_.
// Throughput is set by the single parser step and the 64-bit delta adders.
// s_ready drops only while the skid slot of the result register is full.
// aresetn is synchronous and returns the parser to awaiting a header byte.
module twkb_geometry_stream_decoder_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_first_byte,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [63:0] m_x_coord,
    output logic signed [63:0] m_y_coord,
    output logic signed [3:0]  m_precision_xy,
    output logic [3:0]         m_geom_type,
    output logic               m_ring_end,
    output logic               m_part_end,
    output logic               m_geom_end,
    output logic [1:0]         m_status
);

    logic              accept, res_valid;
    twkb_pkg::result_t res, out_data;

    assign accept = s_valid & s_ready;

    twkb_parser u_parser (
        .aclk(aclk), .aresetn(aresetn), .in_valid(accept),
        .data_byte(s_data_byte), .first_byte(s_first_byte), .last_byte(s_last_byte),
        .res_valid(res_valid), .res(res)
    );

    twkb_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .in_valid(res_valid), .in_data(res),
        .in_ready(s_ready), .out_valid(m_valid), .out_data(out_data), .out_ready(m_ready)
    );

    assign m_kind         = out_data.kind;
    assign m_x_coord      = out_data.x_coord;
    assign m_y_coord      = out_data.y_coord;
    assign m_precision_xy = out_data.precision_xy;
    assign m_geom_type    = out_data.geom_type;
    assign m_ring_end     = out_data.ring_end;
    assign m_part_end     = out_data.part_end;
    assign m_geom_end     = out_data.geom_end;
    assign m_status       = out_data.status;

`ifndef SYNTHESIS
    // Error records always close the geometry
    a_err_geom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == twkb_pkg::KIND_ERROR |-> m_geom_end)
        else $error("error record without geom_end");
    // Only points carry coordinates
    a_coord_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != twkb_pkg::KIND_POINT |-> m_x_coord == 0 && m_y_coord == 0)
        else $error("coordinates on non-point record");
    // A byte with a record taken while stalled must not be dropped
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result lost under stall");
`endif

endmodule
